@@ hdl/a2dte_pkg.sv @@
// Shared types, codes and the micro-program of the 2D affine transform engine.
`default_nettype none
package a2dte_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int ADDR_W = 5;
  localparam int RF_DEPTH = 25;
  localparam int PC_W = 7;
  localparam int ROM_LEN = 88;

  typedef enum logic [2:0] {
    CMD_IDENT  = 3'd0,
    CMD_TRANS  = 3'd1,
    CMD_ROT    = 3'd2,
    CMD_SCALE  = 3'd3,
    CMD_VERTEX = 3'd4
  } cmd_e;

  // register file map
  localparam logic [ADDR_W-1:0] A_M0 = 5'd0;
  localparam logic [ADDR_W-1:0] A_M1 = 5'd1;
  localparam logic [ADDR_W-1:0] A_M2 = 5'd2;
  localparam logic [ADDR_W-1:0] A_M3 = 5'd3;
  localparam logic [ADDR_W-1:0] A_M4 = 5'd4;
  localparam logic [ADDR_W-1:0] A_M5 = 5'd5;
  localparam logic [ADDR_W-1:0] A_T0 = 5'd6;
  localparam logic [ADDR_W-1:0] A_T1 = 5'd7;
  localparam logic [ADDR_W-1:0] A_T2 = 5'd8;
  localparam logic [ADDR_W-1:0] A_T3 = 5'd9;
  localparam logic [ADDR_W-1:0] A_T4 = 5'd10;
  localparam logic [ADDR_W-1:0] A_T5 = 5'd11;
  localparam logic [ADDR_W-1:0] A_S0 = 5'd12;
  localparam logic [ADDR_W-1:0] A_S1 = 5'd13;
  localparam logic [ADDR_W-1:0] A_S2 = 5'd14;
  localparam logic [ADDR_W-1:0] A_S3 = 5'd15;
  localparam logic [ADDR_W-1:0] A_S4 = 5'd16;
  localparam logic [ADDR_W-1:0] A_S5 = 5'd17;
  localparam logic [ADDR_W-1:0] A_A  = 5'd18;
  localparam logic [ADDR_W-1:0] A_B  = 5'd19;
  localparam logic [ADDR_W-1:0] A_PX = 5'd20;
  localparam logic [ADDR_W-1:0] A_PY = 5'd21;
  localparam logic [ADDR_W-1:0] A_ONE = 5'd22;
  localparam logic [ADDR_W-1:0] A_OMA = 5'd23;
  localparam logic [ADDR_W-1:0] A_OMB = 5'd24;
  localparam logic [ADDR_W-1:0] A_OX = 5'd25;
  localparam logic [ADDR_W-1:0] A_OY = 5'd26;

  localparam logic [PC_W-1:0] PC_VERTEX = 7'd0;
  localparam logic [PC_W-1:0] PC_TRANS  = 7'd9;
  localparam logic [PC_W-1:0] PC_ROT    = 7'd20;
  localparam logic [PC_W-1:0] PC_SCALE  = 7'd38;
  localparam logic [PC_W-1:0] PC_PREMUL = 7'd55;

  typedef enum logic [2:0] {
    UOP_MAC = 3'd0,
    UOP_MSC = 3'd1,
    UOP_ADD = 3'd2,
    UOP_SUB = 3'd3,
    UOP_WR  = 3'd4,
    UOP_JMP = 3'd5,
    UOP_END = 3'd6
  } uop_e;

  typedef struct packed {
    uop_e              op;
    logic [ADDR_W-1:0] sa;
    logic [ADDR_W-1:0] sb;
  } uop_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
    logic neg;
    logic prod;
  } mac_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_FETCH = 5'b00100,
    S_EXEC  = 5'b01000,
    S_MACC  = 5'b10000
  } state_e;

  function automatic uop_t mk(input uop_e op, input logic [ADDR_W-1:0] sa,
                              input logic [ADDR_W-1:0] sb);
    uop_t u;
    u.op = op;
    u.sa = sa;
    u.sb = sb;
    return u;
  endfunction

  function automatic uop_t rom_f(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(UOP_MAC, A_M0, A_A);
      7'd1:  u = mk(UOP_MAC, A_M1, A_B);
      7'd2:  u = mk(UOP_ADD, A_M2, A_M2);
      7'd3:  u = mk(UOP_WR, A_OX, A_OX);
      7'd4:  u = mk(UOP_MAC, A_M3, A_A);
      7'd5:  u = mk(UOP_MAC, A_M4, A_B);
      7'd6:  u = mk(UOP_ADD, A_M5, A_M5);
      7'd7:  u = mk(UOP_WR, A_OY, A_OY);
      7'd8:  u = mk(UOP_END, A_M0, A_M0);
      7'd9:  u = mk(UOP_ADD, A_ONE, A_ONE);
      7'd10: u = mk(UOP_WR, A_T0, A_T0);
      7'd11: u = mk(UOP_WR, A_T1, A_T1);
      7'd12: u = mk(UOP_ADD, A_A, A_A);
      7'd13: u = mk(UOP_WR, A_T2, A_T2);
      7'd14: u = mk(UOP_WR, A_T3, A_T3);
      7'd15: u = mk(UOP_ADD, A_ONE, A_ONE);
      7'd16: u = mk(UOP_WR, A_T4, A_T4);
      7'd17: u = mk(UOP_ADD, A_B, A_B);
      7'd18: u = mk(UOP_WR, A_T5, A_T5);
      7'd19: u = mk(UOP_JMP, A_M0, A_M0);
      7'd20: u = mk(UOP_ADD, A_ONE, A_ONE);
      7'd21: u = mk(UOP_SUB, A_A, A_A);
      7'd22: u = mk(UOP_WR, A_OMA, A_OMA);
      7'd23: u = mk(UOP_ADD, A_A, A_A);
      7'd24: u = mk(UOP_WR, A_T0, A_T0);
      7'd25: u = mk(UOP_SUB, A_B, A_B);
      7'd26: u = mk(UOP_WR, A_T1, A_T1);
      7'd27: u = mk(UOP_MAC, A_PX, A_OMA);
      7'd28: u = mk(UOP_MAC, A_PY, A_B);
      7'd29: u = mk(UOP_WR, A_T2, A_T2);
      7'd30: u = mk(UOP_ADD, A_B, A_B);
      7'd31: u = mk(UOP_WR, A_T3, A_T3);
      7'd32: u = mk(UOP_ADD, A_A, A_A);
      7'd33: u = mk(UOP_WR, A_T4, A_T4);
      7'd34: u = mk(UOP_MAC, A_PY, A_OMA);
      7'd35: u = mk(UOP_MSC, A_PX, A_B);
      7'd36: u = mk(UOP_WR, A_T5, A_T5);
      7'd37: u = mk(UOP_JMP, A_M0, A_M0);
      7'd38: u = mk(UOP_ADD, A_ONE, A_ONE);
      7'd39: u = mk(UOP_SUB, A_A, A_A);
      7'd40: u = mk(UOP_WR, A_OMA, A_OMA);
      7'd41: u = mk(UOP_ADD, A_ONE, A_ONE);
      7'd42: u = mk(UOP_SUB, A_B, A_B);
      7'd43: u = mk(UOP_WR, A_OMB, A_OMB);
      7'd44: u = mk(UOP_ADD, A_A, A_A);
      7'd45: u = mk(UOP_WR, A_T0, A_T0);
      7'd46: u = mk(UOP_WR, A_T1, A_T1);
      7'd47: u = mk(UOP_MAC, A_OMA, A_PX);
      7'd48: u = mk(UOP_WR, A_T2, A_T2);
      7'd49: u = mk(UOP_WR, A_T3, A_T3);
      7'd50: u = mk(UOP_ADD, A_B, A_B);
      7'd51: u = mk(UOP_WR, A_T4, A_T4);
      7'd52: u = mk(UOP_MAC, A_OMB, A_PY);
      7'd53: u = mk(UOP_WR, A_T5, A_T5);
      7'd54: u = mk(UOP_JMP, A_M0, A_M0);
      7'd55: u = mk(UOP_MAC, A_T0, A_M0);
      7'd56: u = mk(UOP_MAC, A_T1, A_M3);
      7'd57: u = mk(UOP_WR, A_S0, A_S0);
      7'd58: u = mk(UOP_MAC, A_T3, A_M0);
      7'd59: u = mk(UOP_MAC, A_T4, A_M3);
      7'd60: u = mk(UOP_WR, A_S3, A_S3);
      7'd61: u = mk(UOP_MAC, A_T0, A_M1);
      7'd62: u = mk(UOP_MAC, A_T1, A_M4);
      7'd63: u = mk(UOP_WR, A_S1, A_S1);
      7'd64: u = mk(UOP_MAC, A_T3, A_M1);
      7'd65: u = mk(UOP_MAC, A_T4, A_M4);
      7'd66: u = mk(UOP_WR, A_S4, A_S4);
      7'd67: u = mk(UOP_MAC, A_T0, A_M2);
      7'd68: u = mk(UOP_MAC, A_T1, A_M5);
      7'd69: u = mk(UOP_ADD, A_T2, A_T2);
      7'd70: u = mk(UOP_WR, A_S2, A_S2);
      7'd71: u = mk(UOP_MAC, A_T3, A_M2);
      7'd72: u = mk(UOP_MAC, A_T4, A_M5);
      7'd73: u = mk(UOP_ADD, A_T5, A_T5);
      7'd74: u = mk(UOP_WR, A_S5, A_S5);
      7'd75: u = mk(UOP_ADD, A_S0, A_S0);
      7'd76: u = mk(UOP_WR, A_M0, A_M0);
      7'd77: u = mk(UOP_ADD, A_S1, A_S1);
      7'd78: u = mk(UOP_WR, A_M1, A_M1);
      7'd79: u = mk(UOP_ADD, A_S2, A_S2);
      7'd80: u = mk(UOP_WR, A_M2, A_M2);
      7'd81: u = mk(UOP_ADD, A_S3, A_S3);
      7'd82: u = mk(UOP_WR, A_M3, A_M3);
      7'd83: u = mk(UOP_ADD, A_S4, A_S4);
      7'd84: u = mk(UOP_WR, A_M4, A_M4);
      7'd85: u = mk(UOP_ADD, A_S5, A_S5);
      7'd86: u = mk(UOP_WR, A_M5, A_M5);
      default: u = mk(UOP_END, A_M0, A_M0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

@@ hdl/a2dte_mac.sv @@
// Shared multiply and saturating accumulate unit of the transform engine.
`default_nettype none
module a2dte_mac #(
  parameter int WORD_BITS = a2dte_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = a2dte_pkg::FRAC_BITS_DEF
) (
  input  wire                         clk_i,
  input  a2dte_pkg::mac_ctrl_t        ctrl_i,
  input  wire logic signed [WORD_BITS-1:0] opa_i,
  input  wire logic signed [WORD_BITS-1:0] opb_i,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        res_ovf_o,
  output logic                        mul_ovf_o
);

  localparam int PW = 2 * WORD_BITS;
  localparam int AW = WORD_BITS + 2;
  localparam logic signed [PW-1:0] RND = PW'((64'(1) << FRAC_BITS) - 64'(1));

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] adj;
  logic signed [PW-1:0] sh;
  logic signed [WORD_BITS-1:0] mq;
  logic signed [WORD_BITS-1:0] x;
  logic signed [AW-1:0] xe;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] acc_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= PW'(opa_i) * PW'(opb_i);
    end
  end

  // truncate toward zero, then saturate to the word
  always_comb begin
    adj = prod_q + (prod_q[PW-1] ? RND : '0);
    sh = adj >>> FRAC_BITS;
    mul_ovf_o = !((&sh[PW-1:WORD_BITS-1]) || !(|sh[PW-1:WORD_BITS-1]));
    mq = mul_ovf_o ? {sh[PW-1], {(WORD_BITS-1){~sh[PW-1]}}} : sh[WORD_BITS-1:0];
  end

  always_comb begin
    x = ctrl_i.prod ? mq : opa_i;
    xe = AW'(x);
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc) begin
      acc_d = ctrl_i.neg ? acc_q - xe : acc_q + xe;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    res_ovf_o = !((&acc_q[AW-1:WORD_BITS-1]) || !(|acc_q[AW-1:WORD_BITS-1]));
    res_o = res_ovf_o ? {acc_q[AW-1], {(WORD_BITS-1){~acc_q[AW-1]}}}
                      : acc_q[WORD_BITS-1:0];
  end

endmodule
`default_nettype wire

@@ hdl/affine_2d_transform_engine_unit.sv @@
// Top level of the 2D affine transform engine.
// Holds a 2D affine matrix (six coefficients of the top two rows, reset to identity) and
// takes one command word at a time: identity, translate, rotate about a pivot
// (cosine/sine pair), scale about a point, or transform a vertex, which
// returns one result word. Q16.16 by default; products truncate toward zero,
// sums saturate, and any saturation sets the overflow flag of the result.
// Matrix saturation is sticky until the next identity command. One word is in
// work at a time, from acceptance to ready again. A micro-program runs every
// product through one multiplier and one saturating accumulator: a product passes
// the FETCH, EXEC and MACC states, an add FETCH and EXEC, and a register write
// FETCH alone. A vertex result waits in an output register while the next word
// is accepted.
`default_nettype none
module affine_2d_transform_engine_unit #(
  parameter int FRAC_BITS = a2dte_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = a2dte_pkg::WORD_BITS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // op_a [31:0], op_b [63:32], pivot_x [95:64], pivot_y [127:96]
  input  wire  [127:0] s_axis_tdata,
  // cmd [2:0]
  input  wire  [2:0]   s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // out_x [31:0], out_y [63:32]
  output logic [63:0]  m_axis_tdata,
  // overflow [0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int W = WORD_BITS;
  localparam int XW = (W > 32) ? W + 1 : 33;
  localparam logic ONE_OVF = (FRAC_BITS >= W - 1);
  localparam logic signed [W-1:0] ONE_W = ONE_OVF ? W'((64'(1) << (W - 1)) - 64'(1))
                                                  : W'(64'(1) << FRAC_BITS);

  function automatic logic [W:0] sat_in(input logic [31:0] v);
    logic signed [XW-1:0] e;
    logic ovf;
    e = XW'(signed'(v));
    ovf = !((&e[XW-1:W-1]) || !(|e[XW-1:W-1]));
    return {ovf, ovf ? {e[XW-1], {(W-1){~e[XW-1]}}} : e[W-1:0]};
  endfunction

  function automatic logic [32:0] sat_out(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    logic ovf;
    e = XW'(v);
    ovf = !((&e[XW-1:31]) || !(|e[XW-1:31]));
    return {ovf, ovf ? {e[XW-1], {31{~e[XW-1]}}} : e[31:0]};
  endfunction

  a2dte_pkg::state_e state_q, state_d;
  logic [a2dte_pkg::PC_W-1:0] pc_q, pc_d;
  logic [1:0] lcnt_q;
  a2dte_pkg::cmd_e cmd_q;
  logic last_q;
  logic f_q;
  logic sticky_q;
  logic [5:0] mvalid_q;
  logic signed [W-1:0] in_q [4];
  logic signed [W-1:0] rf_q [a2dte_pkg::RF_DEPTH];
  logic signed [W-1:0] rd1_q, rd2_q;
  logic [31:0] xr_q, yr_q;
  logic ovalid_q, olast_q, oovf_q;
  logic [31:0] ox_q, oy_q;

  a2dte_pkg::uop_t uop;
  a2dte_pkg::mac_ctrl_t ctrl;
  logic signed [W-1:0] mac_res;
  logic res_ovf, mul_ovf;
  logic [32:0] o32;
  logic [W:0] sa_in, sb_in, spx_in, spy_in;
  logic in_acc, out_acc;
  logic we;
  logic [a2dte_pkg::ADDR_W-1:0] wa;
  logic signed [W-1:0] wd;
  logic sub1, sub2;
  logic signed [W-1:0] sv1, sv2;
  logic wr_fire, end_fire;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == a2dte_pkg::S_IDLE);
  assign uop = a2dte_pkg::rom_f(pc_q);

  assign sa_in = sat_in(s_axis_tdata[31:0]);
  assign sb_in = sat_in(s_axis_tdata[63:32]);
  assign spx_in = sat_in(s_axis_tdata[95:64]);
  assign spy_in = sat_in(s_axis_tdata[127:96]);
  assign o32 = sat_out(mac_res);

  assign wr_fire = (state_q == a2dte_pkg::S_FETCH) && (uop.op == a2dte_pkg::UOP_WR);
  assign end_fire = (state_q == a2dte_pkg::S_FETCH) && (uop.op == a2dte_pkg::UOP_END) &&
                    ((cmd_q != a2dte_pkg::CMD_VERTEX) || !ovalid_q || m_axis_tready);

  a2dte_mac #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .opa_i     (rd1_q),
    .opb_i     (rd2_q),
    .res_o     (mac_res),
    .res_ovf_o (res_ovf),
    .mul_ovf_o (mul_ovf)
  );

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    ctrl = '0;
    case (state_q)
      a2dte_pkg::S_IDLE: begin
        ctrl.clr = 1'b1;
        if (in_acc) begin
          case (a2dte_pkg::cmd_e'(s_axis_tuser))
            a2dte_pkg::CMD_TRANS: begin
              state_d = a2dte_pkg::S_LOAD;
              pc_d = a2dte_pkg::PC_TRANS;
            end
            a2dte_pkg::CMD_ROT: begin
              state_d = a2dte_pkg::S_LOAD;
              pc_d = a2dte_pkg::PC_ROT;
            end
            a2dte_pkg::CMD_SCALE: begin
              state_d = a2dte_pkg::S_LOAD;
              pc_d = a2dte_pkg::PC_SCALE;
            end
            a2dte_pkg::CMD_VERTEX: begin
              state_d = a2dte_pkg::S_LOAD;
              pc_d = a2dte_pkg::PC_VERTEX;
            end
            default: begin
              state_d = a2dte_pkg::S_IDLE;
            end
          endcase
        end
      end
      a2dte_pkg::S_LOAD: begin
        if (lcnt_q == 2'd3) begin
          state_d = a2dte_pkg::S_FETCH;
        end
      end
      a2dte_pkg::S_FETCH: begin
        case (uop.op)
          a2dte_pkg::UOP_WR: begin
            ctrl.clr = 1'b1;
            pc_d = pc_q + 1'b1;
          end
          a2dte_pkg::UOP_JMP: begin
            pc_d = a2dte_pkg::PC_PREMUL;
          end
          a2dte_pkg::UOP_END: begin
            if (end_fire) begin
              state_d = a2dte_pkg::S_IDLE;
            end
          end
          default: begin
            state_d = a2dte_pkg::S_EXEC;
          end
        endcase
      end
      a2dte_pkg::S_EXEC: begin
        if (uop.op inside {a2dte_pkg::UOP_MAC, a2dte_pkg::UOP_MSC}) begin
          ctrl.mul = 1'b1;
          state_d = a2dte_pkg::S_MACC;
        end else begin
          ctrl.acc = 1'b1;
          ctrl.neg = (uop.op == a2dte_pkg::UOP_SUB);
          pc_d = pc_q + 1'b1;
          state_d = a2dte_pkg::S_FETCH;
        end
      end
      a2dte_pkg::S_MACC: begin
        ctrl.acc = 1'b1;
        ctrl.prod = 1'b1;
        ctrl.neg = (uop.op == a2dte_pkg::UOP_MSC);
        pc_d = pc_q + 1'b1;
        state_d = a2dte_pkg::S_FETCH;
      end
      default: begin
        state_d = a2dte_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = uop.sa;
    wd = mac_res;
    if (state_q == a2dte_pkg::S_LOAD) begin
      we = 1'b1;
      wa = a2dte_pkg::A_A + a2dte_pkg::ADDR_W'(lcnt_q);
      wd = in_q[lcnt_q];
    end else if (wr_fire && (uop.sa < a2dte_pkg::A_OX)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      rf_q[wa] <= wd;
    end
  end

  // substitute the constant one and coefficients not written since identity or reset
  always_comb begin
    sub1 = (uop.sa == a2dte_pkg::A_ONE) ||
           ((uop.sa < a2dte_pkg::A_T0) && !mvalid_q[uop.sa[2:0]]);
    sub2 = (uop.sb == a2dte_pkg::A_ONE) ||
           ((uop.sb < a2dte_pkg::A_T0) && !mvalid_q[uop.sb[2:0]]);
    sv1 = (uop.sa == a2dte_pkg::A_ONE || uop.sa == a2dte_pkg::A_M0 ||
           uop.sa == a2dte_pkg::A_M4) ? ONE_W : '0;
    sv2 = (uop.sb == a2dte_pkg::A_ONE || uop.sb == a2dte_pkg::A_M0 ||
           uop.sb == a2dte_pkg::A_M4) ? ONE_W : '0;
  end

  always_ff @(posedge clk_i) begin
    rd1_q <= sub1 ? sv1 : rf_q[uop.sa];
    rd2_q <= sub2 ? sv2 : rf_q[uop.sb];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q[0] <= sa_in[W-1:0];
      in_q[1] <= sb_in[W-1:0];
      in_q[2] <= spx_in[W-1:0];
      in_q[3] <= spy_in[W-1:0];
      last_q <= s_axis_tlast;
    end
    if (wr_fire && uop.sa == a2dte_pkg::A_OX) begin
      xr_q <= o32[31:0];
    end
    if (wr_fire && uop.sa == a2dte_pkg::A_OY) begin
      yr_q <= o32[31:0];
    end
    if (end_fire && cmd_q == a2dte_pkg::CMD_VERTEX) begin
      ox_q <= xr_q;
      oy_q <= yr_q;
      olast_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= a2dte_pkg::S_IDLE;
      pc_q <= '0;
      lcnt_q <= '0;
      cmd_q <= a2dte_pkg::CMD_IDENT;
      f_q <= 1'b0;
      sticky_q <= ONE_OVF;
      mvalid_q <= '0;
      ovalid_q <= 1'b0;
      oovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      if (state_q == a2dte_pkg::S_LOAD) begin
        lcnt_q <= lcnt_q + 1'b1;
      end else begin
        lcnt_q <= '0;
      end
      if (in_acc) begin
        cmd_q <= a2dte_pkg::cmd_e'(s_axis_tuser);
        f_q <= ONE_OVF | sa_in[W] | sb_in[W] | spx_in[W] | spy_in[W];
        if (a2dte_pkg::cmd_e'(s_axis_tuser) == a2dte_pkg::CMD_IDENT) begin
          mvalid_q <= '0;
          sticky_q <= ONE_OVF;
        end
      end else if (state_q == a2dte_pkg::S_MACC) begin
        f_q <= f_q | mul_ovf;
      end else if (wr_fire) begin
        f_q <= f_q | res_ovf |
               (((uop.sa == a2dte_pkg::A_OX) || (uop.sa == a2dte_pkg::A_OY)) & o32[32]);
      end
      if (wr_fire && uop.sa < a2dte_pkg::A_T0) begin
        mvalid_q[uop.sa[2:0]] <= 1'b1;
      end
      if (end_fire && cmd_q != a2dte_pkg::CMD_VERTEX) begin
        sticky_q <= sticky_q | f_q;
      end
      if (end_fire && cmd_q == a2dte_pkg::CMD_VERTEX) begin
        ovalid_q <= 1'b1;
        oovf_q <= f_q | sticky_q;
      end else if (out_acc) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {oy_q, ox_q};
  assign m_axis_tlast = olast_q;
  assign m_axis_tuser = oovf_q;

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < a2dte_pkg::PC_W'(a2dte_pkg::ROM_LEN))
    else $error("micro-program counter out of range");

  a_ident_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser == a2dte_pkg::CMD_IDENT) |=> (mvalid_q == '0))
    else $error("identity did not restore the matrix");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == a2dte_pkg::S_FETCH && cmd_q == a2dte_pkg::CMD_VERTEX))
    else $error("result raised outside a vertex end");

  a_sticky_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sticky_q) |-> $past(in_acc && s_axis_tuser == a2dte_pkg::CMD_IDENT))
    else $error("sticky overflow cleared without identity");

endmodule
`default_nettype wire
